// ----- rtl/obbsat_pkg.sv -----
package obbsat_pkg;

  localparam int unsigned FIELD_W             = 48;
  localparam int unsigned COMPONENT_WIDTH_DEF = 16;
  localparam int unsigned NUM_FIELDS          = 12;

  // fixed-point layout: positions Q.8, axes Q.14
  localparam int unsigned POS_FRAC  = 8;
  localparam int unsigned AXIS_FRAC = 14;
  localparam int unsigned EPS_SHIFT = 20;
  localparam int unsigned BIAS_SH   = 2 * AXIS_FRAC - EPS_SHIFT;
  localparam int unsigned SH_T      = 2 * AXIS_FRAC;
  localparam int unsigned SH_E      = 3 * AXIS_FRAC - POS_FRAC;
  localparam int unsigned SH_ER     = AXIS_FRAC - POS_FRAC;

  localparam int unsigned NUM_AXES  = 15;
  localparam logic [3:0]  AXIS_NONE = 4'd15;

  typedef struct packed {
    logic [FIELD_W-1:0] center_a;
    logic [FIELD_W-1:0] center_b;
    logic [FIELD_W-1:0] axis_a0;
    logic [FIELD_W-1:0] axis_a1;
    logic [FIELD_W-1:0] axis_a2;
    logic [FIELD_W-1:0] axis_b0;
    logic [FIELD_W-1:0] axis_b1;
    logic [FIELD_W-1:0] axis_b2;
    logic [FIELD_W-1:0] half_a;
    logic [FIELD_W-1:0] half_b;
    logic [FIELD_W-1:0] scale_a;
    logic [FIELD_W-1:0] scale_b;
  } obbsat_in_t;

  typedef struct packed {
    logic       overlap;
    logic [3:0] separating_axis;
  } obbsat_out_t;

endpackage

// ----- rtl/obbsat_frame.sv -----
module obbsat_frame import obbsat_pkg::*; #(
  parameter int unsigned CW = COMPONENT_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  obbsat_in_t            item_i,
  output logic                  valid_o,
  output logic signed [2*CW-1:0] ea_o [3],
  output logic signed [2*CW-1:0] eb_o [3],
  output logic signed [2*CW+1:0] r_o  [3][3],
  output logic signed [2*CW+2:0] ar_o [3][3],
  output logic signed [2*CW+2:0] t_o  [3]
);

  logic [FIELD_W-1:0]         fld [NUM_FIELDS];
  logic [3*CW+FIELD_W-1:0]    pad [NUM_FIELDS];
  logic signed [CW-1:0]       cmp [NUM_FIELDS][3];
  logic signed [CW:0]         d   [3];

  logic                       v1_q;
  logic signed [2*CW-1:0]     ea1_q [3];
  logic signed [2*CW-1:0]     eb1_q [3];
  logic signed [2*CW-1:0]     rp_q  [3][3][3];
  logic signed [2*CW:0]       tp_q  [3][3];

  logic                       v2_q;
  logic signed [2*CW-1:0]     ea2_q [3];
  logic signed [2*CW-1:0]     eb2_q [3];
  logic signed [2*CW+1:0]     r_d   [3][3];
  logic signed [2*CW+1:0]     r_q   [3][3];
  logic signed [2*CW+2:0]     ar_d  [3][3];
  logic signed [2*CW+2:0]     ar_q  [3][3];
  logic signed [2*CW+2:0]     t_d   [3];
  logic signed [2*CW+2:0]     t_q   [3];
  logic signed [2*CW+2:0]     rx    [3][3];

  assign fld[0]  = item_i.center_a;
  assign fld[1]  = item_i.center_b;
  assign fld[2]  = item_i.axis_a0;
  assign fld[3]  = item_i.axis_a1;
  assign fld[4]  = item_i.axis_a2;
  assign fld[5]  = item_i.axis_b0;
  assign fld[6]  = item_i.axis_b1;
  assign fld[7]  = item_i.axis_b2;
  assign fld[8]  = item_i.half_a;
  assign fld[9]  = item_i.half_b;
  assign fld[10] = item_i.scale_a;
  assign fld[11] = item_i.scale_b;

  // bits above the 48-bit field read as zero for wide components
  for (genvar f = 0; f < NUM_FIELDS; f++) begin : g_fld
    assign pad[f] = {{(3*CW){1'b0}}, fld[f]};
    for (genvar k = 0; k < 3; k++) begin : g_cmp
      assign cmp[f][k] = pad[f][k*CW +: CW];
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_d
    assign d[k] = (CW+1)'(cmp[1][k]) - (CW+1)'(cmp[0][k]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      ea1_q[k] <= (2*CW)'(cmp[8][k]) * (2*CW)'(cmp[10][k]);
      eb1_q[k] <= (2*CW)'(cmp[9][k]) * (2*CW)'(cmp[11][k]);
    end
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        tp_q[i][k] <= (2*CW+1)'(d[k]) * (2*CW+1)'(cmp[2+i][k]);
        for (int j = 0; j < 3; j++) begin
          rp_q[i][j][k] <= (2*CW)'(cmp[2+i][k]) * (2*CW)'(cmp[5+j][k]);
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t_d[i] = (2*CW+3)'(tp_q[i][0]) + (2*CW+3)'(tp_q[i][1]) + (2*CW+3)'(tp_q[i][2]);
      for (int j = 0; j < 3; j++) begin
        r_d[i][j]  = (2*CW+2)'(rp_q[i][j][0]) + (2*CW+2)'(rp_q[i][j][1])
                   + (2*CW+2)'(rp_q[i][j][2]);
        rx[i][j]   = (2*CW+3)'(r_d[i][j]);
        ar_d[i][j] = ((rx[i][j] < 0) ? -rx[i][j] : rx[i][j])
                   + ((2*CW+3)'(1) << BIAS_SH);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ea2_q <= ea1_q;
    eb2_q <= eb1_q;
    r_q   <= r_d;
    ar_q  <= ar_d;
    t_q   <= t_d;
  end

  assign valid_o = v2_q;
  assign ea_o    = ea2_q;
  assign eb_o    = eb2_q;
  assign r_o     = r_q;
  assign ar_o    = ar_q;
  assign t_o     = t_q;

endmodule

// ----- rtl/obbsat_proj.sv -----
module obbsat_proj import obbsat_pkg::*; #(
  parameter int unsigned CW = COMPONENT_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic signed [2*CW-1:0] ea_i [3],
  input  logic signed [2*CW-1:0] eb_i [3],
  input  logic signed [2*CW+1:0] r_i  [3][3],
  input  logic signed [2*CW+2:0] ar_i [3][3],
  input  logic signed [2*CW+2:0] t_i  [3],
  output logic                   valid_o,
  output logic [NUM_AXES-1:0]    sep_o
);

  localparam int unsigned PW = 4*CW + 6;
  localparam int unsigned XW = 4*CW + 16;

  logic                   v3_q;
  logic                   v4_q;
  // eaar[a][b][j] = ea[a]*AR[b][j], ebar[c][i][d] = eb[c]*AR[i][d],
  // tr[a][b][j] = t[a]*R[b][j]
  logic signed [PW-1:0]   eaar_q [3][3][3];
  logic signed [PW-1:0]   ebar_q [3][3][3];
  logic signed [PW-1:0]   tr_q   [3][3][3];
  logic signed [2*CW-1:0] ea3_q  [3];
  logic signed [2*CW-1:0] eb3_q  [3];
  logic signed [2*CW+2:0] t3_q   [3];

  logic [NUM_AXES-1:0]    sep_d;
  logic [NUM_AXES-1:0]    sep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v3_q <= valid_i;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        for (int j = 0; j < 3; j++) begin
          eaar_q[a][b][j] <= PW'(ea_i[a]) * PW'(ar_i[b][j]);
          ebar_q[a][b][j] <= PW'(eb_i[a]) * PW'(ar_i[b][j]);
          tr_q[a][b][j]   <= PW'(t_i[a])  * PW'(r_i[b][j]);
        end
      end
    end
    ea3_q <= ea_i;
    eb3_q <= eb_i;
    t3_q  <= t_i;
  end

  always_comb begin
    logic signed [XW-1:0] lhs, ra, rb, rhs, mag;
    int unsigned i1, i2, j1, j2;
    sep_d = '0;
    for (int i = 0; i < 3; i++) begin
      // A axes
      lhs = XW'(t3_q[i]) <<< SH_T;
      rb  = XW'(ebar_q[0][i][0]) + XW'(ebar_q[1][i][1]) + XW'(ebar_q[2][i][2]);
      rhs = (XW'(ea3_q[i]) <<< SH_E) + (rb <<< SH_ER);
      mag = (lhs < 0) ? -lhs : lhs;
      sep_d[i] = mag > rhs;
      // B axes
      lhs = XW'(tr_q[0][0][i]) + XW'(tr_q[1][1][i]) + XW'(tr_q[2][2][i]);
      ra  = XW'(eaar_q[0][0][i]) + XW'(eaar_q[1][1][i]) + XW'(eaar_q[2][2][i]);
      rhs = (ra <<< SH_ER) + (XW'(eb3_q[i]) <<< SH_E);
      mag = (lhs < 0) ? -lhs : lhs;
      sep_d[3+i] = mag > rhs;
    end
    for (int i = 0; i < 3; i++) begin
      i1 = (i + 1) % 3;
      i2 = (i + 2) % 3;
      for (int j = 0; j < 3; j++) begin
        j1 = (j + 1) % 3;
        j2 = (j + 2) % 3;
        ra  = XW'(eaar_q[i1][i2][j]) + XW'(eaar_q[i2][i1][j]);
        rb  = XW'(ebar_q[j1][i][j2]) + XW'(ebar_q[j2][i][j1]);
        lhs = XW'(tr_q[i2][i1][j]) - XW'(tr_q[i1][i2][j]);
        mag = (lhs < 0) ? -lhs : lhs;
        sep_d[6+3*i+j] = mag > ((ra + rb) <<< SH_ER);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sep_q <= sep_d;
  end

  assign valid_o = v4_q;
  assign sep_o   = sep_q;

endmodule

// ----- rtl/obb_overlap_separating_axis_core.sv -----
// Oriented-box overlap test by separating axes. One box pair is taken with
// start in every cycle; busy is always low. The result (overlap, or the
// first separating axis in the order A axes, B axes, nine crosses) comes
// out with done_o, one result per pair, in order, after the pair has passed
// the five register stages: extent and component products, rotation and
// projection sums, wide products, the fifteen compares, and the priority
// pick into the output register.
// done_o lasts one cycle and the receiver cannot hold it off.
module obb_overlap_separating_axis_core import obbsat_pkg::*; #(
  parameter int unsigned COMPONENT_WIDTH = COMPONENT_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  obbsat_in_t  item_i,
  output logic        done_o,
  output obbsat_out_t res_o
);

  localparam int unsigned CW = COMPONENT_WIDTH;

  logic                   fr_valid;
  logic signed [2*CW-1:0] ea [3];
  logic signed [2*CW-1:0] eb [3];
  logic signed [2*CW+1:0] r  [3][3];
  logic signed [2*CW+2:0] ar [3][3];
  logic signed [2*CW+2:0] t  [3];

  logic                   pj_valid;
  logic [NUM_AXES-1:0]    sep;

  logic                   done_q;
  obbsat_out_t            res_d;
  obbsat_out_t            res_q;

  assign busy = 1'b0;

  obbsat_frame #(.CW(CW)) u_frame (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start),
    .item_i  (item_i),
    .valid_o (fr_valid),
    .ea_o    (ea),
    .eb_o    (eb),
    .r_o     (r),
    .ar_o    (ar),
    .t_o     (t)
  );

  obbsat_proj #(.CW(CW)) u_proj (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr_valid),
    .ea_i    (ea),
    .eb_i    (eb),
    .r_i     (r),
    .ar_i    (ar),
    .t_i     (t),
    .valid_o (pj_valid),
    .sep_o   (sep)
  );

  // lowest-numbered separating axis wins
  always_comb begin
    res_d.overlap         = 1'b1;
    res_d.separating_axis = AXIS_NONE;
    for (int n = NUM_AXES - 1; n >= 0; n--) begin
      if (sep[n]) begin
        res_d.overlap         = 1'b0;
        res_d.separating_axis = 4'(n);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= pj_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
